/* hdl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition leads to a consequence in the next cycle.
`define ASSERT_NEXT(label, clk_s, rst_s, cond, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |=> (cons)) \
        else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_NOW(label, clk_s, rst_s, cond, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (cond) |-> (cons)) \
        else $error(msg);

`endif

/* hdl/tvm_pkg.sv */
// Shared types, sizes and codes of the ternary weight matrix-vector unit.
`timescale 1ns / 1ps

package tvm_pkg;

    // Store and accumulator sizes
    localparam int IN_MAX      = 256;
    localparam int OUT_MAX     = 64;
    localparam int POS_W       = $clog2(IN_MAX);
    localparam int COL_W       = $clog2(OUT_MAX);

    // Fixed field widths
    localparam int IN_DIM_W    = 9;
    localparam int OUT_DIM_W   = 7;
    localparam int WROW_W      = 8;
    localparam int WCOL_W      = 6;
    localparam int WVAL_W      = 2;
    localparam int ACT_W       = 8;
    localparam int SUM_W       = 17;
    localparam int ROWCNT_W    = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    // Item kinds
    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_ACT    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_DIM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DIM = 1'b1;

    // Ternary weight codes
    localparam logic [WVAL_W-1:0] W_PLUS  = 2'b01;
    localparam logic [WVAL_W-1:0] W_MINUS = 2'b11;

    // One classified item as it travels through the queue
    typedef struct packed {
        logic                     kind;
        logic                     wr_ok;
        logic [WROW_W-1:0]        weight_row;
        logic [WCOL_W-1:0]        weight_col;
        logic [WVAL_W-1:0]        weight_value;
        logic signed [ACT_W-1:0]  activation;
    } item_t;

    // Effective dimensions, clamped to their legal ranges
    typedef struct packed {
        logic [IN_DIM_W-1:0]  n_in;
        logic [OUT_DIM_W-1:0] n_out;
    } dims_t;

endpackage

/* hdl/ternary_weight_matvec.sv */
// Top level of the ternary weight matrix-vector unit.
`timescale 1ns / 1ps

// An item is transferred when start is high and busy is low. Weight writes (kind 0) and
// activations (kind 1) enter a four-entry queue and are carried out one per cycle by the
// back end while it is not finishing a row. It reads one 64-entry weight row per
// activation and updates all column sums together. After the in_dim-th activation of a
// row the back end takes no further items until it has finished the sums and loaded the
// result register for each column in turn. A row's results pass through the weight row
// and activation registers, the column sums and the result register, then appear one per
// cycle, column 0 first, on result_valid for exactly one cycle each, with last_of_row on
// the final column. The receiver cannot stall; results must be taken as they appear. busy
// rises only while the queue is full. The weight store is not cleared at reset: every
// entry read by an activation must have been written first. Configuration writes are
// always taken (cfg_ready is tied high) and must only be issued while the block is idle.
module ternary_weight_matvec (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tvm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tvm_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   kind,
    input  logic [tvm_pkg::WROW_W-1:0]             weight_row,
    input  logic [tvm_pkg::WCOL_W-1:0]             weight_col,
    input  logic signed [tvm_pkg::WVAL_W-1:0]      weight_value,
    input  logic signed [tvm_pkg::ACT_W-1:0]       activation,
    output logic                                   result_valid,
    output logic [tvm_pkg::ROWCNT_W-1:0]           row,
    output logic [tvm_pkg::WCOL_W-1:0]             column,
    output logic signed [tvm_pkg::SUM_W-1:0]       sum,
    output logic                                   last_of_row
);

    tvm_pkg::item_t  push_item;
    tvm_pkg::item_t  head;
    tvm_pkg::dims_t  dims;
    logic            push;
    logic            pop;
    logic            q_empty;
    logic            q_full;

    // Classify and push
    tvm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .weight_row   (weight_row),
        .weight_col   (weight_col),
        .weight_value (weight_value),
        .activation   (activation),
        .q_full       (q_full),
        .push         (push),
        .item         (push_item),
        .dims         (dims)
    );

    // Decouple front and back
    tvm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Execute and emit
    tvm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (q_empty),
        .dims         (dims),
        .pop          (pop),
        .result_valid (result_valid),
        .row          (row),
        .column       (column),
        .sum          (sum),
        .last_of_row  (last_of_row)
    );

endmodule

/* hdl/tvm_front.sv */
// Front part: configuration registers, input classification and push.
`timescale 1ns / 1ps

module tvm_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [tvm_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [tvm_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                   start,
    output logic                                   busy,
    input  logic                                   kind,
    input  logic [tvm_pkg::WROW_W-1:0]             weight_row,
    input  logic [tvm_pkg::WCOL_W-1:0]             weight_col,
    input  logic signed [tvm_pkg::WVAL_W-1:0]      weight_value,
    input  logic signed [tvm_pkg::ACT_W-1:0]       activation,
    input  logic                                   q_full,
    output logic                                   push,
    output tvm_pkg::item_t                         item,
    output tvm_pkg::dims_t                         dims
);

    logic [tvm_pkg::IN_DIM_W-1:0]  in_dim_reg;
    logic [tvm_pkg::OUT_DIM_W-1:0] out_dim_reg;

    // Register writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_dim_reg  <= tvm_pkg::IN_DIM_W'(256);
            out_dim_reg <= tvm_pkg::OUT_DIM_W'(64);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tvm_pkg::REG_IN_DIM:  in_dim_reg  <= cfg_data;
                tvm_pkg::REG_OUT_DIM: out_dim_reg <= cfg_data[tvm_pkg::OUT_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp dimensions to one and to the store size
    always_comb
    begin
        if (in_dim_reg == '0)
            dims.n_in = tvm_pkg::IN_DIM_W'(1);
        else if (int'(in_dim_reg) > tvm_pkg::IN_MAX)
            dims.n_in = tvm_pkg::IN_DIM_W'(tvm_pkg::IN_MAX);
        else
            dims.n_in = in_dim_reg;

        if (out_dim_reg == '0)
            dims.n_out = tvm_pkg::OUT_DIM_W'(1);
        else if (int'(out_dim_reg) > tvm_pkg::OUT_MAX)
            dims.n_out = tvm_pkg::OUT_DIM_W'(tvm_pkg::OUT_MAX);
        else
            dims.n_out = out_dim_reg;
    end

    // Classify the item and flag weight writes that fall outside the store
    always_comb
    begin
        item.kind         = kind;
        item.wr_ok        = (int'(weight_row) < tvm_pkg::IN_MAX) &&
                            (int'(weight_col) < tvm_pkg::OUT_MAX);
        item.weight_row   = weight_row;
        item.weight_col   = weight_col;
        item.weight_value = weight_value;
        item.activation   = activation;
    end

    // Accept while the queue has room
    assign busy = q_full;
    assign push = start && !q_full;

endmodule

/* hdl/tvm_queue.sv */
// Short first-in first-out queue of classified items between front and back.
`timescale 1ns / 1ps

module tvm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tvm_pkg::item_t  push_item,
    input  logic            pop,
    output tvm_pkg::item_t  head,
    output logic            empty,
    output logic            full
);

    tvm_pkg::item_t              entry_reg [tvm_pkg::QUEUE_DEPTH];
    logic [tvm_pkg::QA_W-1:0]    wr_ptr_reg;
    logic [tvm_pkg::QA_W-1:0]    rd_ptr_reg;
    logic [tvm_pkg::QA_W:0]      count_reg;
    logic [tvm_pkg::QA_W:0]      count_next;

    assign empty = (count_reg == '0);
    assign full  = (int'(count_reg) == tvm_pkg::QUEUE_DEPTH);
    assign head  = entry_reg[rd_ptr_reg];

    // Track fill level
    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && !empty))
            count_next = count_reg + 1'b1;
        else if (!push && pop && !empty)
            count_next = count_reg - 1'b1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

/* hdl/tvm_back.sv */
// Back part: weight store, column accumulators and result emission.
`timescale 1ns / 1ps

module tvm_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tvm_pkg::item_t                        head,
    input  logic                                  empty,
    input  tvm_pkg::dims_t                        dims,
    output logic                                  pop,
    output logic                                  result_valid,
    output logic [tvm_pkg::ROWCNT_W-1:0]          row,
    output logic [tvm_pkg::WCOL_W-1:0]            column,
    output logic signed [tvm_pkg::SUM_W-1:0]      sum,
    output logic                                  last_of_row
);

    // Weight store: one row of OUT_MAX 2-bit codes per inner position
    logic [tvm_pkg::OUT_MAX-1:0][tvm_pkg::WVAL_W-1:0] wmem [tvm_pkg::IN_MAX];
    logic [tvm_pkg::OUT_MAX-1:0][tvm_pkg::WVAL_W-1:0] rd_row_reg;

    logic signed [tvm_pkg::SUM_W-1:0] acc_reg  [tvm_pkg::OUT_MAX];
    logic signed [tvm_pkg::SUM_W-1:0] acc_next [tvm_pkg::OUT_MAX];

    logic [tvm_pkg::POS_W-1:0]        pos_reg;
    logic [tvm_pkg::ROWCNT_W-1:0]     row_cnt_reg;
    logic signed [tvm_pkg::ACT_W-1:0] act_reg;
    logic                             acc_v_reg;
    logic                             clr_reg;
    logic                             done_reg;
    logic                             wait_reg;
    logic                             emit_reg;
    logic [tvm_pkg::COL_W-1:0]        col_reg;

    logic                             is_act;
    logic                             row_done;
    logic                             emit_last;
    logic [tvm_pkg::IN_DIM_W-1:0]     pos_inc;

    logic [tvm_pkg::ROWCNT_W-1:0]     row_out_reg;
    logic [tvm_pkg::COL_W-1:0]        col_out_reg;
    logic signed [tvm_pkg::SUM_W-1:0] sum_out_reg;
    logic                             last_out_reg;
    logic                             valid_out_reg;

    // Take the next item unless a row is being finished or emitted
    assign pop      = !empty && !wait_reg;
    assign is_act   = (head.kind == tvm_pkg::KIND_ACT);
    assign pos_inc  = tvm_pkg::IN_DIM_W'(pos_reg) + 1'b1;
    assign row_done = (pos_inc >= dims.n_in);
    assign emit_last = ({1'b0, col_reg} + 1'b1) == tvm_pkg::OUT_DIM_W'(dims.n_out);

    // Write one weight entry or read one weight row
    always_ff @(posedge clk)
    begin
        if (pop && !is_act && head.wr_ok)
            wmem[tvm_pkg::POS_W'(head.weight_row)][tvm_pkg::COL_W'(head.weight_col)]
                <= head.weight_value;
        if (pop && is_act)
        begin
            rd_row_reg <= wmem[pos_reg];
            act_reg    <= head.activation;
        end
    end

    // Update every column lane: clear on first activation, add or subtract, saturate
    always_comb
    begin
        logic signed [tvm_pkg::SUM_W:0] base;
        logic signed [tvm_pkg::SUM_W:0] ext;
        logic signed [tvm_pkg::SUM_W:0] total;
        base  = '0;
        ext   = '0;
        total = '0;
        for (int c = 0; c < tvm_pkg::OUT_MAX; c++)
        begin
            base  = clr_reg ? '0 : (tvm_pkg::SUM_W+1)'(acc_reg[c]);
            ext   = (tvm_pkg::SUM_W+1)'(act_reg);
            case (rd_row_reg[c])
                tvm_pkg::W_PLUS:  total = base + ext;
                tvm_pkg::W_MINUS: total = base - ext;
                default:          total = base;
            endcase
            if (total[tvm_pkg::SUM_W] != total[tvm_pkg::SUM_W-1])
                acc_next[c] = total[tvm_pkg::SUM_W] ?
                    {1'b1, {(tvm_pkg::SUM_W-1){1'b0}}} : {1'b0, {(tvm_pkg::SUM_W-1){1'b1}}};
            else
                acc_next[c] = total[tvm_pkg::SUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < tvm_pkg::OUT_MAX; c++)
                acc_reg[c] <= '0;
        end
        else if (acc_v_reg)
        begin
            for (int c = 0; c < tvm_pkg::OUT_MAX; c++)
                acc_reg[c] <= acc_next[c];
        end
    end

    // Sequence positions, row completion and emission
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            row_cnt_reg   <= '0;
            acc_v_reg     <= 1'b0;
            clr_reg       <= 1'b0;
            done_reg      <= 1'b0;
            wait_reg      <= 1'b0;
            emit_reg      <= 1'b0;
            col_reg       <= '0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            acc_v_reg     <= pop && is_act;
            valid_out_reg <= emit_reg;
            if (pop && is_act)
            begin
                clr_reg  <= (pos_reg == '0);
                done_reg <= row_done;
                pos_reg  <= row_done ? '0 : tvm_pkg::POS_W'(pos_inc);
                if (row_done)
                    wait_reg <= 1'b1;
            end
            // Start emitting once the final activation has been summed
            if (acc_v_reg && done_reg)
            begin
                emit_reg <= 1'b1;
                col_reg  <= '0;
            end
            if (emit_reg)
            begin
                if (emit_last)
                begin
                    emit_reg    <= 1'b0;
                    wait_reg    <= 1'b0;
                    row_cnt_reg <= row_cnt_reg + 1'b1;
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
        end
    end

    // Load the result register one column per cycle
    always_ff @(posedge clk)
    begin
        if (emit_reg)
        begin
            row_out_reg  <= row_cnt_reg;
            col_out_reg  <= col_reg;
            sum_out_reg  <= acc_reg[col_reg];
            last_out_reg <= emit_last;
        end
    end

    assign result_valid = valid_out_reg;
    assign row          = row_out_reg;
    assign column       = tvm_pkg::WCOL_W'(col_out_reg);
    assign sum          = sum_out_reg;
    assign last_of_row  = valid_out_reg && last_out_reg;

endmodule

/* hdl/tvm_checker.sv */
// Port-level checker of the ternary weight matrix-vector unit and its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tvm_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   result_valid,
    input  logic [tvm_pkg::ROWCNT_W-1:0]           row,
    input  logic [tvm_pkg::WCOL_W-1:0]             column,
    input  logic                                   last_of_row
);

    // A row's results come as one unbroken burst
    `ASSERT_NEXT(a_burst, clk, rst_n, result_valid && !last_of_row, result_valid, "burst broken")

    // Columns step by one within a burst
    `ASSERT_NEXT(a_col_step, clk, rst_n, result_valid && !last_of_row,
        column == $past(column) + 1'b1, "column skipped")

    // Row number holds within a burst
    `ASSERT_NEXT(a_row_hold, clk, rst_n, result_valid && !last_of_row,
        row == $past(row), "row changed mid-burst")

    // A burst ends with a gap
    `ASSERT_NEXT(a_gap, clk, rst_n, result_valid && last_of_row, !result_valid, "no gap after row")

    // A burst opens at column zero
    `ASSERT_NOW(a_first_col, clk, rst_n, result_valid && !$past(result_valid),
        column == '0, "burst not at column zero")

endmodule

bind ternary_weight_matvec tvm_checker u_tvm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .row          (row),
    .column       (column),
    .last_of_row  (last_of_row)
);

/* tb/sv/testbench.sv */
// Self-checking testbench of the ternary weight matrix-vector unit.
`timescale 1ns / 1ps

module testbench;
    import tvm_pkg::*;

    localparam int GAP_MAX       = 19;
    localparam int SETTLE_CYCLES = 24;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 10;
    localparam int FILL_ROWS     = 3;

    // Weight codes that count as zero
    localparam logic [WVAL_W-1:0] W_ZERO    = 2'b00;
    localparam logic [WVAL_W-1:0] W_NEG_TWO = 2'b10;

    // One pending transfer: a register write or a stream item
    typedef struct {
        bit                  is_cfg;
        bit [CFG_IDX_W-1:0]  reg_index;
        bit [CFG_DATA_W-1:0] reg_data;
        bit                  kind;
        bit [WROW_W-1:0]     wrow;
        bit [WCOL_W-1:0]     wcol;
        bit [WVAL_W-1:0]     wval;
        bit [ACT_W-1:0]      act;
        int                  gap;
    } stim_t;

    // One column sum as it should leave the block
    typedef struct {
        bit [ROWCNT_W-1:0] row_num;
        bit [WCOL_W-1:0]   col;
        bit [SUM_W-1:0]    col_sum;
        bit                last;
    } col_result_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index    = '0;
    logic [CFG_DATA_W-1:0]       cfg_data     = '0;
    logic                        start        = 1'b0;
    logic                        busy;
    logic                        kind         = 1'b0;
    logic [WROW_W-1:0]           weight_row   = '0;
    logic [WCOL_W-1:0]           weight_col   = '0;
    logic signed [WVAL_W-1:0]    weight_value = '0;
    logic signed [ACT_W-1:0]     activation   = '0;
    logic                        result_valid;
    logic [ROWCNT_W-1:0]         row;
    logic [WCOL_W-1:0]           column;
    logic signed [SUM_W-1:0]     sum;
    logic                        last_of_row;

    // Mirror of the block state
    bit [WVAL_W-1:0]    weight_mirror [IN_MAX][OUT_MAX];
    int                 col_acc [OUT_MAX];
    int                 inner_pos;
    bit [ROWCNT_W-1:0]  rows_done;
    bit [IN_DIM_W-1:0]  in_dim_reg  = 9'd256;
    bit [OUT_DIM_W-1:0] out_dim_reg = 7'd64;

    col_result_t        sum_expect [$];
    stim_t              pending_items [$];
    stim_t              cur_item;
    bit                 in_flight;
    int                 hold_cnt;
    int                 mismatch_count = 0;
    bit                 burst = 1'b1;

    ternary_weight_matvec dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .kind         (kind),
        .weight_row   (weight_row),
        .weight_col   (weight_col),
        .weight_value (weight_value),
        .activation   (activation),
        .result_valid (result_valid),
        .row          (row),
        .column       (column),
        .sum          (sum),
        .last_of_row  (last_of_row)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Update the mirror with one accepted item and queue the column sums it completes
    function void predict_item(stim_t it);
        int          n_in;
        int          n_out;
        int          a;
        int          c;
        col_result_t r;
        if (it.kind == KIND_WEIGHT)
        begin
            weight_mirror[it.wrow][it.wcol] = it.wval;
            return;
        end
        a = $signed(it.act);
        if (in_dim_reg == 0)
            n_in = 1;
        else if (in_dim_reg > IN_MAX)
            n_in = IN_MAX;
        else
            n_in = int'(in_dim_reg);
        if (out_dim_reg == 0)
            n_out = 1;
        else if (out_dim_reg > OUT_MAX)
            n_out = OUT_MAX;
        else
            n_out = int'(out_dim_reg);
        // clear the accumulators on the first activation of a row
        if (inner_pos == 0)
            for (c = 0; c < OUT_MAX; c++)
                col_acc[c] = 0;
        if (inner_pos < IN_MAX)
            for (c = 0; c < OUT_MAX; c++)
            begin
                if (weight_mirror[inner_pos][c] == W_PLUS)
                    col_acc[c] += a;
                else if (weight_mirror[inner_pos][c] == W_MINUS)
                    col_acc[c] -= a;
            end
        inner_pos = (inner_pos + 1) % 512;
        if (inner_pos < n_in && inner_pos != 0)
            return;
        // row done: one sum per emitted column
        for (c = 0; c < n_out; c++)
        begin
            r.row_num = rows_done;
            r.col     = WCOL_W'(c);
            r.col_sum = col_acc[c][SUM_W-1:0];
            r.last    = (c + 1 == n_out);
            sum_expect.push_back(r);
        end
        inner_pos = 0;
        rows_done++;
    endfunction

    // Drive the ports from the pending queue, one transfer at a time
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_valid <= 1'b0;
            in_flight = 1'b0;
            hold_cnt  = 0;
        end
        else
        begin
            // retire the transfer that completes at this edge
            if (in_flight && ((start && !busy) || (cfg_valid && cfg_ready)))
            begin
                if (!cur_item.is_cfg)
                    predict_item(cur_item);
                else if (cur_item.reg_index == REG_IN_DIM)
                    in_dim_reg = cur_item.reg_data[IN_DIM_W-1:0];
                else
                    out_dim_reg = cur_item.reg_data[OUT_DIM_W-1:0];
                in_flight = 1'b0;
            end
            // take the next item once its gap has run out
            if (!in_flight && pending_items.size() != 0)
            begin
                if (hold_cnt < pending_items[0].gap)
                    hold_cnt++;
                else
                begin
                    cur_item  = pending_items.pop_front();
                    in_flight = 1'b1;
                    hold_cnt  = 0;
                end
            end
            start        <= in_flight && !cur_item.is_cfg;
            cfg_valid    <= in_flight && cur_item.is_cfg;
            cfg_index    <= cur_item.reg_index;
            cfg_data     <= cur_item.reg_data;
            kind         <= cur_item.kind;
            weight_row   <= cur_item.wrow;
            weight_col   <= cur_item.wcol;
            weight_value <= cur_item.wval;
            activation   <= cur_item.act;
        end
    end

    function void check_field(string name, bit [SUM_W-1:0] want, logic [SUM_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare every result strobe with the oldest expected column sum
    always @(posedge clk)
    begin
        col_result_t want;
        if (rst_n && result_valid)
        begin
            if (sum_expect.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual row %0d column %0d sum %0d",
                         $time, row, column, sum);
                mismatch_count++;
            end
            else
            begin
                want = sum_expect.pop_front();
                check_field("row", SUM_W'(want.row_num), SUM_W'(row));
                check_field("column", SUM_W'(want.col), SUM_W'(column));
                check_field("sum", want.col_sum, sum);
                check_field("last_of_row", SUM_W'(want.last), SUM_W'(last_of_row));
            end
        end
    end

    function int draw_gap();
        return burst ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    function void push_weight(bit [WROW_W-1:0] r, bit [WCOL_W-1:0] c, bit [WVAL_W-1:0] v);
        stim_t it;
        it.is_cfg    = 1'b0;
        it.reg_index = CFG_IDX_W'($urandom);
        it.reg_data  = CFG_DATA_W'($urandom);
        it.kind      = KIND_WEIGHT;
        it.wrow      = r;
        it.wcol      = c;
        it.wval      = v;
        it.act       = ACT_W'($urandom);
        it.gap       = draw_gap();
        pending_items.push_back(it);
    endfunction

    function void push_act(bit [ACT_W-1:0] a);
        stim_t it;
        it.is_cfg    = 1'b0;
        it.reg_index = CFG_IDX_W'($urandom);
        it.reg_data  = CFG_DATA_W'($urandom);
        it.kind      = KIND_ACT;
        it.wrow      = WROW_W'($urandom);
        it.wcol      = WCOL_W'($urandom);
        it.wval      = WVAL_W'($urandom);
        it.act       = a;
        it.gap       = draw_gap();
        pending_items.push_back(it);
    endfunction

    function void push_cfg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
        stim_t it;
        it.is_cfg    = 1'b1;
        it.reg_index = idx;
        it.reg_data  = data;
        it.kind      = KIND_WEIGHT;
        it.wrow      = '0;
        it.wcol      = '0;
        it.wval      = '0;
        it.act       = '0;
        it.gap       = 0;
        pending_items.push_back(it);
    endfunction

    // Hold until everything is sent, every sum has arrived and the block has drained
    task wait_idle();
        int quiet;
        quiet = 0;
        while (quiet < SETTLE_CYCLES)
        begin
            @(negedge clk);
            if (pending_items.size() == 0 && !in_flight && sum_expect.size() == 0)
                quiet++;
            else
                quiet = 0;
        end
    endtask

    initial
    begin : stimulus
        int                  r;
        int                  c;
        int                  n;
        int                  k;
        bit [WVAL_W-1:0]     code;
        bit [CFG_DATA_W-1:0] dim;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // fill the rows in use: column 0 all +1, column 1 all -1, then both zero codes
        burst = 1'b1;
        for (r = 0; r < FILL_ROWS; r++)
            for (c = 0; c < OUT_MAX; c++)
            begin
                case (c)
                    0:       code = W_PLUS;
                    1:       code = W_MINUS;
                    2:       code = W_NEG_TWO;
                    3:       code = W_ZERO;
                    default: code = WVAL_W'($urandom);
                endcase
                push_weight(WROW_W'(r), WCOL_W'(c), code);
            end
        burst = 1'b0;
        wait_idle();

        // one row of the most negative activation across every column
        push_cfg(REG_IN_DIM, CFG_DATA_W'(FILL_ROWS));
        repeat (FILL_ROWS) push_act(8'h80);
        wait_idle();

        // zero dimensions act as one
        push_cfg(REG_IN_DIM, '0);
        push_cfg(REG_OUT_DIM, '0);
        push_act(8'h7F);
        push_act(8'h80);
        push_act(8'h00);
        push_act(8'hFF);
        wait_idle();

        // oversized dimensions act as the maxima: the row stays open
        push_cfg(REG_IN_DIM, '1);
        push_cfg(REG_OUT_DIM, '1);
        repeat (FILL_ROWS - 1) push_act(ACT_W'($urandom));
        wait_idle();

        // shrink the row length below the position reached
        push_cfg(REG_IN_DIM, CFG_DATA_W'(1));
        push_act(8'h7F);
        wait_idle();

        // rewrite weights of later positions in the middle of a row
        push_cfg(REG_IN_DIM, CFG_DATA_W'(FILL_ROWS));
        push_cfg(REG_OUT_DIM, 9'd2);
        push_act(8'd100);
        push_weight(1, 0, W_MINUS);
        push_weight(1, 1, W_NEG_TWO);
        push_act(-8'sd77);
        push_weight(2, 0, W_PLUS);
        push_weight(2, 1, W_ZERO);
        push_act(8'd55);
        push_weight(IN_MAX - 1, OUT_MAX - 1, W_MINUS);

        // random phases: mostly activations, some weight rewrites, new dimensions each time
        for (k = 0; k < RAND_PHASES; k++)
        begin
            wait_idle();
            burst = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 3))
                0:       dim = '0;
                default: dim = CFG_DATA_W'($urandom_range(1, FILL_ROWS));
            endcase
            push_cfg(REG_IN_DIM, dim);
            push_cfg(REG_OUT_DIM, CFG_DATA_W'($urandom));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 4) == 0)
                    push_weight(WROW_W'($urandom), WCOL_W'($urandom), WVAL_W'($urandom));
                else
                    push_act(ACT_W'($urandom));
            end
        end
        wait_idle();

        if (mismatch_count == 0)
            $display("PASS ternary_weight_matvec");
        else
            $display("FAIL ternary_weight_matvec");
        $finish;
    end

    // Drop the run if it hangs
    initial
    begin
        #1000000;
        $display("FAIL ternary_weight_matvec");
        $finish;
    end

endmodule

/* ternary_weight_matvec.f */
+incdir+hdl
hdl/tvm_pkg.sv
hdl/tvm_front.sv
hdl/tvm_queue.sv
hdl/tvm_back.sv
hdl/ternary_weight_matvec.sv
hdl/tvm_checker.sv
tb/sv/testbench.sv
